/* design/srrw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared constants, types and helpers for the selective-repeat receive window.
// ----------------------------------------------------------------------------
package srrw_pkg;

  localparam int WINDOW    = 16;
  localparam int SEQ_SPACE = 256;
  localparam int SEQ_W     = 8;
  localparam int TAG_BITS  = 16;
  localparam int TAG_W     = 16;
  localparam int SIZE_W    = 8;
  localparam int NSLOTS    = WINDOW + 1;
  localparam int SLOT_W    = $clog2(NSLOTS);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [SEQ_W-1:0]  seq_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLASS,
    ST_HEAD,
    ST_RUN
  } state_t;

  typedef enum logic {
    KIND_ACK     = 1'b0,
    KIND_DELIVER = 1'b1
  } kind_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   size;
    logic [TAG_BITS-1:0] tag;
  } slot_ent_t;

  typedef struct packed {
    logic      en;
    slot_t     addr;
    slot_ent_t data;
  } slot_wr_t;

  // Distance from b forward to a, modulo the sequence space.
  function automatic seq_t seq_diff(input seq_t a, input seq_t b);
    logic [SEQ_W:0] t;
    if (a >= b) begin
      t = {1'b0, a} - {1'b0, b};
    end else begin
      t = {1'b0, a} + (SEQ_W + 1)'(SEQ_SPACE) - {1'b0, b};
    end
    return t[SEQ_W-1:0];
  endfunction

  function automatic seq_t seq_inc(input seq_t s);
    if (s == SEQ_W'(SEQ_SPACE - 1)) begin
      return '0;
    end
    return s + SEQ_W'(1);
  endfunction

  function automatic slot_t slot_inc(input slot_t s);
    if (s == SLOT_W'(NSLOTS - 1)) begin
      return '0;
    end
    return s + SLOT_W'(1);
  endfunction

  // Slot of a segment d ahead of the base slot; d is below the window size.
  function automatic slot_t slot_add(input slot_t s, input seq_t d);
    logic [SEQ_W:0] t;
    t = (SEQ_W + 1)'(s) + {1'b0, d};
    if (t >= (SEQ_W + 1)'(NSLOTS)) begin
      t = t - (SEQ_W + 1)'(NSLOTS);
    end
    return t[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* design/srrw_slot_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srrw_slot_mem
// Segment store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srrw_slot_mem
  import srrw_pkg::*;
(
  input  wire logic      clk,
  input  wire slot_wr_t  wr,
  input  wire slot_t     rd_addr,
  output slot_ent_t      rd_data
);

  slot_ent_t mem [NSLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* design/selective_repeat_receive_window.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Receive side of a selective-repeat link: ack, buffer and in-order delivery.
// ----------------------------------------------------------------------------
// A header is taken when start is high and busy is low. Results leave one a
// cycle on out_valid and cannot be held off; the last result of a header has
// out_last_of_run set. A non-data or corrupted header is dropped at the take
// edge; busy never rises for it. A far, old or out-of-order header passes
// through take and classify. A header at the window base goes on to head
// and, if buffered segments follow it, to run, where each released segment
// costs one read of the segment memory. Slot occupancy lives in flip-flops
// cleared by reset, so no clearing pass runs.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window
  import srrw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_is_data,
  input  wire logic              in_checksum_ok,
  input  wire logic [SEQ_W-1:0]  in_seq_num,
  input  wire logic [SIZE_W-1:0] in_data_size,
  input  wire logic [TAG_W-1:0]  in_payload_tag,
  output logic                   out_valid,
  output logic                   out_result_kind,
  output logic [SEQ_W-1:0]       out_ack_seq,
  output logic [TAG_W-1:0]       out_tag,
  output logic [SIZE_W-1:0]      out_seg_size,
  output logic                   out_last_of_run
);

  state_t              state_r, state_nxt;
  logic [NSLOTS-1:0]   full_r, full_nxt;
  slot_t               base_slot_r, base_slot_nxt;
  seq_t                base_seq_r, base_seq_nxt;
  slot_t               slot_r, slot_nxt;
  seq_t                seq_r;
  logic [SIZE_W-1:0]   size_r;
  logic [TAG_BITS-1:0] tag_r;

  slot_wr_t  wr;
  slot_ent_t rd_data;
  seq_t      d_fwd, d_back;
  slot_t     wslot, run_next;
  logic      take;

  assign take  = start && !busy;
  assign busy  = (state_r != ST_IDLE);
  assign d_fwd  = seq_diff(seq_r, base_seq_r);
  assign d_back = seq_diff(base_seq_r, seq_r);
  assign wslot    = slot_add(base_slot_r, d_fwd);
  assign run_next = slot_inc(slot_r);

  srrw_slot_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (slot_nxt),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      full_r      <= '0;
      base_slot_r <= '0;
      base_seq_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      full_r      <= full_nxt;
      base_slot_r <= base_slot_nxt;
      base_seq_r  <= base_seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    if (take) begin
      seq_r  <= in_seq_num;
      size_r <= in_data_size;
      tag_r  <= in_payload_tag[TAG_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt       = state_r;
    full_nxt        = full_r;
    base_slot_nxt   = base_slot_r;
    base_seq_nxt    = base_seq_r;
    slot_nxt        = slot_r;
    wr.en           = 1'b0;
    wr.addr         = wslot;
    wr.data.size    = size_r;
    wr.data.tag     = tag_r;
    out_valid       = 1'b0;
    out_result_kind = KIND_ACK;
    out_ack_seq     = '0;
    out_tag         = '0;
    out_seg_size    = '0;
    out_last_of_run = 1'b0;

    case (state_r)
      ST_IDLE: begin
        // drop non-data and corrupted beats right here
        if (take && in_is_data && in_checksum_ok) begin
          state_nxt = ST_CLASS;
        end
      end
      ST_CLASS: begin
        state_nxt = ST_IDLE;
        if (d_fwd < SEQ_W'(WINDOW)) begin
          out_valid   = 1'b1;
          out_ack_seq = seq_r;
          if (d_fwd == '0) begin
            // start the run: prefetch the slot after the base
            slot_nxt  = slot_inc(base_slot_r);
            state_nxt = ST_HEAD;
          end else begin
            out_last_of_run = 1'b1;
            // keep the first copy of a duplicate
            if (!full_r[wslot]) begin
              wr.en           = 1'b1;
              full_nxt[wslot] = 1'b1;
            end
          end
        end else if (d_back <= SEQ_W'(WINDOW)) begin
          out_valid       = 1'b1;
          out_ack_seq     = seq_r;
          out_last_of_run = 1'b1;
        end
      end
      ST_HEAD: begin
        out_valid       = 1'b1;
        out_result_kind = KIND_DELIVER;
        out_tag         = TAG_W'(tag_r);
        out_seg_size    = size_r;
        out_last_of_run = !full_r[slot_r];
        base_seq_nxt    = seq_inc(base_seq_r);
        if (!full_r[slot_r]) begin
          base_slot_nxt = slot_r;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        out_valid        = 1'b1;
        out_result_kind  = KIND_DELIVER;
        out_tag          = TAG_W'(rd_data.tag);
        out_seg_size     = rd_data.size;
        full_nxt[slot_r] = 1'b0;
        base_seq_nxt     = seq_inc(base_seq_r);
        slot_nxt         = run_next;
        // stop at the first hole or after a full turn of the ring
        if (run_next == base_slot_r || !full_r[run_next]) begin
          out_last_of_run = 1'b1;
          base_slot_nxt   = run_next;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/srrw_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srrw_checker
// Port-level checks for the receive window, bound to the top level.
// ----------------------------------------------------------------------------
module srrw_checker
  import srrw_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic              out_result_kind,
  input wire logic [SEQ_W-1:0]  out_ack_seq,
  input wire logic [TAG_W-1:0]  out_tag,
  input wire logic [SIZE_W-1:0] out_seg_size,
  input wire logic              out_last_of_run
);

  // no result beat while a new header is being taken
  a_no_out_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> !out_valid)
    else $error("result beat while idle");

  // a finished run frees the block
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_run) |=> !busy)
    else $error("busy after last beat");

  // a delivery follows an ack or another delivery of the same run
  a_deliver_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind) |-> $past(out_valid) && !$past(out_last_of_run))
    else $error("delivery outside a run");

  a_ack_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_result_kind) |-> (out_tag == '0 && out_seg_size == '0))
    else $error("ack carries segment fields");

  a_deliver_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind) |-> (out_ack_seq == '0))
    else $error("delivery carries ack number");

endmodule

bind selective_repeat_receive_window srrw_checker u_srrw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_result_kind (out_result_kind),
  .out_ack_seq     (out_ack_seq),
  .out_tag         (out_tag),
  .out_seg_size    (out_seg_size),
  .out_last_of_run (out_last_of_run)
);
`default_nettype wire
